// ===== src/cwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types and constants for the collision window monitor: command codes,
// configuration register indexes, window depths and derived widths.
// ----------------------------------------------------------------------------
package cwm_pkg;

    // Window depths and joint count
    localparam int VOTE_WINDOW  = 16;
    localparam int SIGMA_WINDOW = 16;
    localparam int JOINT_COUNT  = 7;

    // Fixed field widths
    localparam int VOTE_W      = 10;
    localparam int VALUE_W     = 32;
    localparam int ERR_FIELDS  = 7;
    localparam int OUT_SUM_W   = 14;
    localparam int OUT_SUM_MAX = (1 << OUT_SUM_W) - 1;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    // Configuration field widths
    localparam int CLASS_W      = 4;
    localparam int VOTE_THR_W   = 14;
    localparam int SIGMA_THR_W  = 31;
    localparam int SIGMA_NEED_W = 5;
    localparam int BLANK_W      = 16;

    // Derived widths
    localparam int VSLOT_W = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
    localparam int SSLOT_W = (SIGMA_WINDOW > 1) ? $clog2(SIGMA_WINDOW) : 1;
    localparam int VSUM_W  = $clog2(VOTE_WINDOW * ((1 << VOTE_W) - 1) + 1);
    localparam int SSUM_W  = $clog2(SIGMA_WINDOW + 1);
    localparam int JIDX_W  = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int VOTE_SUM_MAX = VOTE_WINDOW * ((1 << VOTE_W) - 1);

    // Reset values of the configuration registers
    localparam int RST_CLASS      = 0;
    localparam int RST_VOTE_THR   = 8;
    localparam int RST_VOTE_EN    = 1;
    localparam int RST_SIGMA_THR  = 65536;
    localparam int RST_SIGMA_NEED = 4;
    localparam int RST_SIGMA_EN   = 1;
    localparam int RST_ERROR_EN   = 1;
    localparam int RST_BLANK      = 1200;

    typedef enum logic [2:0] {
        CMD_VOTE    = 3'd0,
        CMD_SIGMA   = 3'd1,
        CMD_ERRORS  = 3'd2,
        CMD_START   = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_TRIGGER = 3'd5,
        CMD_TICK    = 3'd6,
        CMD_BOUNDS  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        REG_COLLISION_CLASS    = 3'd0,
        REG_VOTE_THRESHOLD     = 3'd1,
        REG_VOTE_ENABLE        = 3'd2,
        REG_SIGMA_THRESHOLD    = 3'd3,
        REG_SIGMA_COUNT_NEEDED = 3'd4,
        REG_SIGMA_ENABLE       = 3'd5,
        REG_ERROR_ENABLE       = 3'd6,
        REG_BLANK_TICKS        = 3'd7
    } cfg_idx_t;

endpackage

// ===== src/collision_window_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// collision_window_monitor_unit
// Latching collision detector fed by vote, sigma and joint-error words.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ channel (valid/ready); each carries a command
//   and its operands. Every accepted word yields exactly one result word on
//   the m_ channel: collision event, latch state, zero request and the
//   current vote window sum.
//   Configuration registers sit on the APB port at byte address 4*index;
//   the user writes them only while the block is idle, which the block
//   does not enforce; pready is always high. Throughput: one word per
//   cycle unless stalled. The vote and sigma windows are single-port rings
//   read at acceptance and written back from the working stage; a write to
//   the slot being read is forwarded.
//   Reset: the latch comes up set (detected), windows read as zero, blanking
//   is off and the configuration takes its default values. Joint bounds hold
//   no defined value until loaded with a set-bounds word. No clearing pass.
//   Stall: while m_ready is low the result register holds; one more word is
//   taken into the working stage, then s_ready drops until the result moves.
// ----------------------------------------------------------------------------
module collision_window_monitor_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_command,
    input  logic [3:0]                          s_source_id,
    input  logic [3:0]                          s_class_index,
    input  logic [cwm_pkg::VOTE_W-1:0]          s_vote,
    input  logic signed [31:0]                  s_sigma_value,
    input  logic signed [31:0]                  s_err_a,
    input  logic signed [31:0]                  s_err_b,
    input  logic signed [31:0]                  s_err_c,
    input  logic signed [31:0]                  s_err_d,
    input  logic signed [31:0]                  s_err_e,
    input  logic signed [31:0]                  s_err_f,
    input  logic signed [31:0]                  s_err_g,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_collision_event,
    output logic                                m_detected,
    output logic                                m_zero_request,
    output logic [cwm_pkg::OUT_SUM_W-1:0]       m_window_vote_sum,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cwm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cwm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cwm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cwm_pkg::CLASS_W-1:0]      cfg_class_reg;
    logic [cwm_pkg::VOTE_THR_W-1:0]   cfg_vote_thr_reg;
    logic                             cfg_vote_en_reg;
    logic [cwm_pkg::SIGMA_THR_W-1:0]  cfg_sigma_thr_reg;
    logic [cwm_pkg::SIGMA_NEED_W-1:0] cfg_sigma_need_reg;
    logic                             cfg_sigma_en_reg;
    logic                             cfg_error_en_reg;
    logic [cwm_pkg::BLANK_W-1:0]      cfg_blank_reg;

    logic               apb_wr;
    cwm_pkg::cfg_idx_t  apb_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign apb_idx = cwm_pkg::cfg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_class_reg      <= cwm_pkg::CLASS_W'(cwm_pkg::RST_CLASS);
            cfg_vote_thr_reg   <= cwm_pkg::VOTE_THR_W'(cwm_pkg::RST_VOTE_THR);
            cfg_vote_en_reg    <= 1'(cwm_pkg::RST_VOTE_EN);
            cfg_sigma_thr_reg  <= cwm_pkg::SIGMA_THR_W'(cwm_pkg::RST_SIGMA_THR);
            cfg_sigma_need_reg <= cwm_pkg::SIGMA_NEED_W'(cwm_pkg::RST_SIGMA_NEED);
            cfg_sigma_en_reg   <= 1'(cwm_pkg::RST_SIGMA_EN);
            cfg_error_en_reg   <= 1'(cwm_pkg::RST_ERROR_EN);
            cfg_blank_reg      <= cwm_pkg::BLANK_W'(cwm_pkg::RST_BLANK);
        end else if (apb_wr && pready) begin
            unique case (apb_idx)
                cwm_pkg::REG_COLLISION_CLASS:
                    cfg_class_reg <= pwdata[cwm_pkg::CLASS_W-1:0];
                cwm_pkg::REG_VOTE_THRESHOLD:
                    cfg_vote_thr_reg <= pwdata[cwm_pkg::VOTE_THR_W-1:0];
                cwm_pkg::REG_VOTE_ENABLE:
                    cfg_vote_en_reg <= pwdata[0];
                cwm_pkg::REG_SIGMA_THRESHOLD:
                    cfg_sigma_thr_reg <= pwdata[cwm_pkg::SIGMA_THR_W-1:0];
                cwm_pkg::REG_SIGMA_COUNT_NEEDED:
                    cfg_sigma_need_reg <= pwdata[cwm_pkg::SIGMA_NEED_W-1:0];
                cwm_pkg::REG_SIGMA_ENABLE:
                    cfg_sigma_en_reg <= pwdata[0];
                cwm_pkg::REG_ERROR_ENABLE:
                    cfg_error_en_reg <= pwdata[0];
                cwm_pkg::REG_BLANK_TICKS:
                    cfg_blank_reg <= pwdata[cwm_pkg::BLANK_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (apb_idx)
            cwm_pkg::REG_COLLISION_CLASS:
                prdata = cwm_pkg::APB_DATA_W'(cfg_class_reg);
            cwm_pkg::REG_VOTE_THRESHOLD:
                prdata = cwm_pkg::APB_DATA_W'(cfg_vote_thr_reg);
            cwm_pkg::REG_VOTE_ENABLE:
                prdata = cwm_pkg::APB_DATA_W'(cfg_vote_en_reg);
            cwm_pkg::REG_SIGMA_THRESHOLD:
                prdata = cwm_pkg::APB_DATA_W'(cfg_sigma_thr_reg);
            cwm_pkg::REG_SIGMA_COUNT_NEEDED:
                prdata = cwm_pkg::APB_DATA_W'(cfg_sigma_need_reg);
            cwm_pkg::REG_SIGMA_ENABLE:
                prdata = cwm_pkg::APB_DATA_W'(cfg_sigma_en_reg);
            cwm_pkg::REG_ERROR_ENABLE:
                prdata = cwm_pkg::APB_DATA_W'(cfg_error_en_reg);
            cwm_pkg::REG_BLANK_TICKS:
                prdata = cwm_pkg::APB_DATA_W'(cfg_blank_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s1_adv;
    logic s1_fire;
    logic s_accept;

    assign s1_adv   = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Acceptance stage: capture the word, precompute the sigma flag
    // ------------------------------------------------------------------
    logic [31:0] sig_mag;
    logic        sig_flag;
    logic signed [31:0] err_in [cwm_pkg::ERR_FIELDS];

    assign sig_mag  = s_sigma_value[31] ? (~s_sigma_value + 32'd1) : s_sigma_value;
    assign sig_flag = sig_mag > {1'b0, cfg_sigma_thr_reg};

    assign err_in[0] = s_err_a;
    assign err_in[1] = s_err_b;
    assign err_in[2] = s_err_c;
    assign err_in[3] = s_err_d;
    assign err_in[4] = s_err_e;
    assign err_in[5] = s_err_f;
    assign err_in[6] = s_err_g;

    cwm_pkg::cmd_t              s1_cmd_reg;
    logic [3:0]                 s1_src_reg;
    logic [3:0]                 s1_cls_reg;
    logic [cwm_pkg::VOTE_W-1:0] s1_vote_reg;
    logic                       s1_flag_reg;
    logic signed [31:0]         s1_err_reg [cwm_pkg::ERR_FIELDS];

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= cwm_pkg::cmd_t'(s_command);
            s1_src_reg  <= s_source_id;
            s1_cls_reg  <= s_class_index;
            s1_vote_reg <= s_vote;
            s1_flag_reg <= sig_flag;
            s1_err_reg  <= err_in;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    logic [cwm_pkg::VSUM_W-1:0]  vote_total_reg,  vote_total_next;
    logic [cwm_pkg::VSLOT_W-1:0] vote_slot_reg,   vote_slot_next;
    logic [cwm_pkg::SSUM_W-1:0]  sigma_total_reg, sigma_total_next;
    logic [cwm_pkg::SSLOT_W-1:0] sigma_slot_reg,  sigma_slot_next;
    logic                        latched_reg,     latched_next;
    logic [cwm_pkg::BLANK_W-1:0] blank_left_reg,  blank_left_next;

    // Window rings: single-port style, read at acceptance, written back
    logic [cwm_pkg::VOTE_W-1:0]    vote_ram  [cwm_pkg::VOTE_WINDOW];
    logic                          sigma_ram [cwm_pkg::SIGMA_WINDOW];
    logic [cwm_pkg::VOTE_WINDOW-1:0]  vote_vld_reg;
    logic [cwm_pkg::SIGMA_WINDOW-1:0] sigma_vld_reg;

    logic [cwm_pkg::VOTE_W-1:0] vote_rd_reg;
    logic                       vote_rd_vld_reg;
    logic                       vote_fwd_reg;
    logic [cwm_pkg::VOTE_W-1:0] vote_fwd_data_reg;
    logic                       sigma_rd_reg;
    logic                       sigma_rd_vld_reg;
    logic                       sigma_fwd_reg;
    logic                       sigma_fwd_data_reg;

    logic                       vote_we;
    logic                       sigma_we;

    // Joint bounds: undefined until loaded
    logic signed [31:0] low_bounds_reg  [cwm_pkg::JOINT_COUNT];
    logic signed [31:0] high_bounds_reg [cwm_pkg::JOINT_COUNT];
    logic               bounds_we;

    // Result register payload
    logic                          m_event_reg,   m_event_next;
    logic                          m_zero_reg,    m_zero_next;
    logic [cwm_pkg::OUT_SUM_W-1:0] m_sum_reg,     m_sum_next;

    // ------------------------------------------------------------------
    // Working stage: read-modify-write of the windows and the latch
    // ------------------------------------------------------------------
    logic [cwm_pkg::VOTE_W-1:0] vote_old;
    logic                       sigma_old;
    logic [cwm_pkg::VSUM_W-1:0] vote_sum_new;
    logic [cwm_pkg::SSUM_W-1:0] sigma_sum_new;
    logic                       out_of_bounds;
    logic                       do_fire;

    assign vote_old  = vote_fwd_reg ? vote_fwd_data_reg
                     : (vote_rd_vld_reg ? vote_rd_reg : '0);
    assign sigma_old = sigma_fwd_reg ? sigma_fwd_data_reg
                     : (sigma_rd_vld_reg & sigma_rd_reg);

    assign vote_sum_new  = vote_total_reg - cwm_pkg::VSUM_W'(vote_old)
                         + cwm_pkg::VSUM_W'(s1_vote_reg);
    assign sigma_sum_new = sigma_total_reg - cwm_pkg::SSUM_W'(sigma_old)
                         + cwm_pkg::SSUM_W'(s1_flag_reg);

    always_comb begin
        out_of_bounds = 1'b0;
        for (int j = 0; j < cwm_pkg::JOINT_COUNT; j++) begin
            if (s1_err_reg[j] < low_bounds_reg[j] || s1_err_reg[j] > high_bounds_reg[j])
                out_of_bounds = 1'b1;
        end
    end

    always_comb begin
        vote_total_next  = vote_total_reg;
        vote_slot_next   = vote_slot_reg;
        sigma_total_next = sigma_total_reg;
        sigma_slot_next  = sigma_slot_reg;
        latched_next     = latched_reg;
        blank_left_next  = blank_left_reg;
        vote_we          = 1'b0;
        sigma_we         = 1'b0;
        bounds_we        = 1'b0;
        do_fire          = 1'b0;
        m_zero_next      = 1'b0;

        if (s1_fire) begin
            unique case (s1_cmd_reg)
                cwm_pkg::CMD_VOTE: begin
                    if (!latched_reg && s1_src_reg == 4'd0 && s1_cls_reg == cfg_class_reg) begin
                        vote_we         = 1'b1;
                        vote_total_next = vote_sum_new;
                        vote_slot_next  = (vote_slot_reg == cwm_pkg::VSLOT_W'(cwm_pkg::VOTE_WINDOW - 1))
                                        ? '0 : vote_slot_reg + 1'b1;
                        do_fire = cfg_vote_en_reg
                               && (32'(vote_sum_new) >= 32'(cfg_vote_thr_reg));
                    end
                end
                cwm_pkg::CMD_SIGMA: begin
                    if (blank_left_reg != '0) begin
                        m_zero_next = 1'b1;
                    end else begin
                        sigma_we         = 1'b1;
                        sigma_total_next = sigma_sum_new;
                        sigma_slot_next  = (sigma_slot_reg == cwm_pkg::SSLOT_W'(cwm_pkg::SIGMA_WINDOW - 1))
                                         ? '0 : sigma_slot_reg + 1'b1;
                        do_fire = cfg_sigma_en_reg
                               && (32'(sigma_sum_new) >= 32'(cfg_sigma_need_reg));
                    end
                end
                cwm_pkg::CMD_ERRORS: begin
                    do_fire = cfg_error_en_reg && out_of_bounds;
                end
                cwm_pkg::CMD_START: begin
                    latched_next    = 1'b0;
                    blank_left_next = cfg_blank_reg;
                end
                cwm_pkg::CMD_STOP: begin
                    latched_next = 1'b1;
                end
                cwm_pkg::CMD_TRIGGER: begin
                    do_fire = 1'b1;
                end
                cwm_pkg::CMD_TICK: begin
                    if (blank_left_reg != '0)
                        blank_left_next = blank_left_reg - 1'b1;
                end
                cwm_pkg::CMD_BOUNDS: begin
                    bounds_we = s1_cls_reg < 4'(cwm_pkg::JOINT_COUNT);
                end
            endcase

            // a set latch absorbs any further detection
            if (do_fire)
                latched_next = 1'b1;
        end

        m_event_next = do_fire && !latched_reg;
        m_sum_next   = (32'(vote_total_next) > 32'(cwm_pkg::OUT_SUM_MAX))
                     ? cwm_pkg::OUT_SUM_W'(cwm_pkg::OUT_SUM_MAX)
                     : cwm_pkg::OUT_SUM_W'(vote_total_next);
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            vote_total_reg  <= '0;
            vote_slot_reg   <= '0;
            sigma_total_reg <= '0;
            sigma_slot_reg  <= '0;
            latched_reg     <= 1'b1;
            blank_left_reg  <= '0;
            vote_vld_reg    <= '0;
            sigma_vld_reg   <= '0;
        end else begin
            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;

            vote_total_reg  <= vote_total_next;
            vote_slot_reg   <= vote_slot_next;
            sigma_total_reg <= sigma_total_next;
            sigma_slot_reg  <= sigma_slot_next;
            latched_reg     <= latched_next;
            blank_left_reg  <= blank_left_next;

            if (vote_we)
                vote_vld_reg[vote_slot_reg] <= 1'b1;
            if (sigma_we)
                sigma_vld_reg[sigma_slot_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Window memories: write back at the working slot, read the next slot
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (vote_we)
            vote_ram[vote_slot_reg] <= s1_vote_reg;
        if (sigma_we)
            sigma_ram[sigma_slot_reg] <= s1_flag_reg;

        if (s_accept) begin
            vote_rd_reg        <= vote_ram[vote_slot_next];
            vote_rd_vld_reg    <= vote_vld_reg[vote_slot_next];
            // forward a write landing on the slot being read
            vote_fwd_reg       <= vote_we && (vote_slot_reg == vote_slot_next);
            vote_fwd_data_reg  <= s1_vote_reg;
            sigma_rd_reg       <= sigma_ram[sigma_slot_next];
            sigma_rd_vld_reg   <= sigma_vld_reg[sigma_slot_next];
            sigma_fwd_reg      <= sigma_we && (sigma_slot_reg == sigma_slot_next);
            sigma_fwd_data_reg <= s1_flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (bounds_we) begin
            low_bounds_reg[s1_cls_reg[cwm_pkg::JIDX_W-1:0]]  <= s1_err_reg[0];
            high_bounds_reg[s1_cls_reg[cwm_pkg::JIDX_W-1:0]] <= s1_err_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic m_detected_reg;

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_event_reg    <= m_event_next;
            m_zero_reg     <= m_zero_next;
            m_sum_reg      <= m_sum_next;
            m_detected_reg <= latched_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_collision_event = m_event_reg;
    assign m_detected        = m_detected_reg;
    assign m_zero_request    = m_zero_reg;
    assign m_window_vote_sum = m_sum_reg;

endmodule

// ===== src/cwm_checker.sv =====
// ----------------------------------------------------------------------------
// cwm_checker
// Port-level checks for the collision window monitor, bound to the top level.
// ----------------------------------------------------------------------------
module cwm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_collision_event,
    input logic                           m_detected,
    input logic                           m_zero_request,
    input logic [cwm_pkg::OUT_SUM_W-1:0]  m_window_vote_sum
);

    // an event always leaves the latch set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_collision_event |-> m_detected)
        else $error("collision event without detected latch");

    // a blanked sigma word never reports a detection
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_request |-> !m_collision_event)
        else $error("zero request together with collision event");

    // window sum never exceeds a full window of maximum votes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_window_vote_sum) <= 32'(cwm_pkg::VOTE_SUM_MAX))
        else $error("window vote sum out of range");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_collision_event)
            && $stable(m_detected) && $stable(m_zero_request)
            && $stable(m_window_vote_sum))
        else $error("result word changed while stalled");

    // an offered input word stays offered until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn before acceptance");

endmodule

bind collision_window_monitor_unit cwm_checker u_cwm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_collision_event (m_collision_event),
    .m_detected        (m_detected),
    .m_zero_request    (m_zero_request),
    .m_window_vote_sum (m_window_vote_sum)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for collision_window_monitor_unit. Drives command words through
// the s_ channel in random bursts, reprograms the registers over APB between
// phases, and checks each result word against a value given in the directed
// table or a cycle-free predictor of the vote window, the sigma flag window,
// the joint bounds and the latch. Constrained-by-hand random traffic follows.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 8;
    localparam int WORDS_PER_PASS = 80;

    typedef struct packed {
        cwm_pkg::cmd_t                        cmd;
        logic [3:0]                           src;
        logic [3:0]                           cls;
        logic [cwm_pkg::VOTE_W-1:0]           vote;
        logic [31:0]                          sigma;
        logic [cwm_pkg::ERR_FIELDS-1:0][31:0] err;
    } word_t;

    typedef struct packed {
        logic                          ev;
        logic                          det;
        logic                          zr;
        logic [cwm_pkg::OUT_SUM_W-1:0] sum;
    } status_t;

    typedef struct packed {
        word_t   w;
        logic    chk;
        status_t r;
    } step_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [2:0]                     s_command;
    logic [3:0]                     s_source_id;
    logic [3:0]                     s_class_index;
    logic [cwm_pkg::VOTE_W-1:0]     s_vote;
    logic signed [31:0]             s_sigma_value;
    logic signed [31:0]             s_err_a, s_err_b, s_err_c, s_err_d, s_err_e, s_err_f, s_err_g;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_collision_event;
    logic                           m_detected;
    logic                           m_zero_request;
    logic [cwm_pkg::OUT_SUM_W-1:0]  m_window_vote_sum;
    logic                           psel, penable, pwrite;
    logic [cwm_pkg::APB_ADDR_W-1:0] paddr;
    logic [cwm_pkg::APB_DATA_W-1:0] pwdata;
    logic [cwm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // predictor copy of the registers
    logic [cwm_pkg::CLASS_W-1:0]      cfg_class;
    logic [cwm_pkg::VOTE_THR_W-1:0]   cfg_vote_thr;
    logic                             cfg_vote_en;
    logic [cwm_pkg::SIGMA_THR_W-1:0]  cfg_sigma_thr;
    logic [cwm_pkg::SIGMA_NEED_W-1:0] cfg_sigma_need;
    logic                             cfg_sigma_en;
    logic                             cfg_error_en;
    logic [cwm_pkg::BLANK_W-1:0]      cfg_blank;

    // predictor state
    logic [cwm_pkg::VOTE_W-1:0]  ring_votes [cwm_pkg::VOTE_WINDOW];
    logic [cwm_pkg::VSUM_W-1:0]  vote_sum;
    logic [cwm_pkg::VSLOT_W-1:0] vote_pos;
    logic                        ring_flags [cwm_pkg::SIGMA_WINDOW];
    logic [cwm_pkg::SSUM_W-1:0]  flag_count;
    logic [cwm_pkg::SSLOT_W-1:0] flag_pos;
    logic                        latch;
    logic [cwm_pkg::BLANK_W-1:0] blank_left;
    logic signed [31:0]          bound_lo [cwm_pkg::JOINT_COUNT];
    logic signed [31:0]          bound_hi [cwm_pkg::JOINT_COUNT];

    status_t status_q [$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;

    collision_window_monitor_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_source_id       (s_source_id),
        .s_class_index     (s_class_index),
        .s_vote            (s_vote),
        .s_sigma_value     (s_sigma_value),
        .s_err_a           (s_err_a),
        .s_err_b           (s_err_b),
        .s_err_c           (s_err_c),
        .s_err_d           (s_err_d),
        .s_err_e           (s_err_e),
        .s_err_f           (s_err_f),
        .s_err_g           (s_err_g),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_collision_event (m_collision_event),
        .m_detected        (m_detected),
        .m_zero_request    (m_zero_request),
        .m_window_vote_sum (m_window_vote_sum),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void set_latch(inout status_t r);
        if (!latch) begin
            latch = 1'b1;
            r.ev  = 1'b1;
        end
    endfunction

    function automatic void predict_status(input word_t w, output status_t r);
        longint mag;
        logic   flag;
        logic   oob;
        int     j;
        r = '0;
        case (w.cmd)
            cwm_pkg::CMD_VOTE: begin
                if (!latch && w.src == 4'd0 && w.cls == cfg_class) begin
                    vote_sum = vote_sum - ring_votes[vote_pos] + w.vote;
                    ring_votes[vote_pos] = w.vote;
                    vote_pos = (vote_pos == cwm_pkg::VSLOT_W'(cwm_pkg::VOTE_WINDOW - 1))
                             ? '0 : vote_pos + 1'b1;
                    if (cfg_vote_en && vote_sum >= cfg_vote_thr)
                        set_latch(r);
                end
            end
            cwm_pkg::CMD_SIGMA: begin
                if (blank_left != '0) begin
                    r.zr = 1'b1;
                end else begin
                    mag = longint'($signed(w.sigma));
                    if (mag < 0)
                        mag = -mag;
                    flag = (mag > longint'(cfg_sigma_thr));
                    flag_count = flag_count - ring_flags[flag_pos] + flag;
                    ring_flags[flag_pos] = flag;
                    flag_pos = (flag_pos == cwm_pkg::SSLOT_W'(cwm_pkg::SIGMA_WINDOW - 1))
                             ? '0 : flag_pos + 1'b1;
                    if (cfg_sigma_en && flag_count >= cfg_sigma_need)
                        set_latch(r);
                end
            end
            cwm_pkg::CMD_ERRORS: begin
                if (cfg_error_en) begin
                    oob = 1'b0;
                    for (j = 0; j < cwm_pkg::JOINT_COUNT; j++)
                        if ($signed(w.err[j]) < bound_lo[j] || $signed(w.err[j]) > bound_hi[j])
                            oob = 1'b1;
                    if (oob)
                        set_latch(r);
                end
            end
            cwm_pkg::CMD_START: begin
                latch = 1'b0;
                blank_left = cfg_blank;
            end
            cwm_pkg::CMD_STOP:    latch = 1'b1;
            cwm_pkg::CMD_TRIGGER: set_latch(r);
            cwm_pkg::CMD_TICK: begin
                if (blank_left != '0)
                    blank_left = blank_left - 1'b1;
            end
            default: begin
                // joint index past the last joint leaves the bounds alone
                if (w.cls < cwm_pkg::JOINT_COUNT) begin
                    bound_lo[w.cls[cwm_pkg::JIDX_W-1:0]] = $signed(w.err[0]);
                    bound_hi[w.cls[cwm_pkg::JIDX_W-1:0]] = $signed(w.err[1]);
                end
            end
        endcase
        r.det = latch;
        r.sum = (vote_sum > cwm_pkg::OUT_SUM_MAX) ? cwm_pkg::OUT_SUM_W'(cwm_pkg::OUT_SUM_MAX)
                                                  : cwm_pkg::OUT_SUM_W'(vote_sum);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [cwm_pkg::OUT_SUM_W-1:0] want,
                                        input logic [cwm_pkg::OUT_SUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_result
        status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                $display("%0t ns: result word with nothing pending, expected none, got %b%b%b/%0d",
                         $time, m_collision_event, m_detected, m_zero_request,
                         m_window_vote_sum);
                err_count++;
            end else begin
                want = status_q.pop_front();
                check_field("collision_event", cwm_pkg::OUT_SUM_W'(want.ev),
                            cwm_pkg::OUT_SUM_W'(m_collision_event));
                check_field("detected", cwm_pkg::OUT_SUM_W'(want.det),
                            cwm_pkg::OUT_SUM_W'(m_detected));
                check_field("zero_request", cwm_pkg::OUT_SUM_W'(want.zr),
                            cwm_pkg::OUT_SUM_W'(m_zero_request));
                check_field("window_vote_sum", want.sum, m_window_vote_sum);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: picks a new stall pattern after each random span; hold_left forces
    // a long hold-off
    // ------------------------------------------------------------------------
    initial begin : receiver
        int span_left;
        int mode;
        int tick_ctr;
        m_ready   = 1'b0;
        span_left = 0;
        mode      = 0;
        tick_ctr  = 0;
        forever begin
            @(negedge aclk);
            if (span_left == 0) begin
                mode      = $urandom_range(0, 3);
                span_left = $urandom_range(20, 80);
            end
            span_left--;
            tick_ctr++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick_ctr % 5 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_word(input word_t w, input logic chk, input status_t given);
        status_t pred;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_command     <= w.cmd;
        s_source_id   <= w.src;
        s_class_index <= w.cls;
        s_vote        <= w.vote;
        s_sigma_value <= w.sigma;
        s_err_a       <= w.err[0];
        s_err_b       <= w.err[1];
        s_err_c       <= w.err[2];
        s_err_d       <= w.err[3];
        s_err_e       <= w.err[4];
        s_err_f       <= w.err[5];
        s_err_g       <= w.err[6];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_status(w, pred);
        status_q.insert(status_q.size(), chk ? given : pred);
    endtask

    // drop valid and wait until every pending result has come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input cwm_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cwm_pkg::REG_COLLISION_CLASS:    cfg_class      = val[cwm_pkg::CLASS_W-1:0];
            cwm_pkg::REG_VOTE_THRESHOLD:     cfg_vote_thr   = val[cwm_pkg::VOTE_THR_W-1:0];
            cwm_pkg::REG_VOTE_ENABLE:        cfg_vote_en    = val[0];
            cwm_pkg::REG_SIGMA_THRESHOLD:    cfg_sigma_thr  = val[cwm_pkg::SIGMA_THR_W-1:0];
            cwm_pkg::REG_SIGMA_COUNT_NEEDED: cfg_sigma_need = val[cwm_pkg::SIGMA_NEED_W-1:0];
            cwm_pkg::REG_SIGMA_ENABLE:       cfg_sigma_en   = val[0];
            cwm_pkg::REG_ERROR_ENABLE:       cfg_error_en   = val[0];
            default:                         cfg_blank      = val[cwm_pkg::BLANK_W-1:0];
        endcase
    endtask

    task automatic load_setting(input int cls, input int vthr, input int ven, input int sthr,
                                input int need, input int sen, input int een, input int blank);
        reg_write(cwm_pkg::REG_COLLISION_CLASS, cls);
        reg_write(cwm_pkg::REG_VOTE_THRESHOLD, vthr);
        reg_write(cwm_pkg::REG_VOTE_ENABLE, ven);
        reg_write(cwm_pkg::REG_SIGMA_THRESHOLD, sthr);
        reg_write(cwm_pkg::REG_SIGMA_COUNT_NEEDED, need);
        reg_write(cwm_pkg::REG_SIGMA_ENABLE, sen);
        reg_write(cwm_pkg::REG_ERROR_ENABLE, een);
        reg_write(cwm_pkg::REG_BLANK_TICKS, blank);
    endtask

    function automatic step_t dstep(input cwm_pkg::cmd_t c, input int src, input int cls,
                                    input int v, input logic [31:0] sig,
                                    input logic [31:0] ea, input logic [31:0] eb,
                                    input logic [31:0] ec,
                                    input int chk, input int ev, input int det, input int zr,
                                    input int sum);
        step_t s;
        s         = '0;
        s.w.cmd   = c;
        s.w.src   = 4'(src);
        s.w.cls   = 4'(cls);
        s.w.vote  = cwm_pkg::VOTE_W'(v);
        s.w.sigma = sig;
        s.w.err[0] = ea;
        s.w.err[1] = eb;
        s.w.err[2] = ec;
        s.chk     = 1'(chk);
        s.r.ev    = 1'(ev);
        s.r.det   = 1'(det);
        s.r.zr    = 1'(zr);
        s.r.sum   = cwm_pkg::OUT_SUM_W'(sum);
        return s;
    endfunction

    // Random word with fields aimed at the interesting spots of the
    // current configuration; unused fields carry random bits.
    function automatic word_t gen_word();
        word_t  w;
        int     pick;
        int     j;
        int     a, b;
        logic   all_in;
        longint span;
        logic [31:0] thr;
        w.src   = 4'($urandom);
        w.cls   = 4'($urandom);
        w.vote  = cwm_pkg::VOTE_W'($urandom);
        w.sigma = $urandom;
        for (j = 0; j < cwm_pkg::ERR_FIELDS; j++)
            w.err[j] = $urandom;
        pick = $urandom_range(0, 99);
        if (latch && pick < 25) begin
            w.cmd = cwm_pkg::CMD_START;
        end else if (blank_left != '0 && pick < 50) begin
            w.cmd = cwm_pkg::CMD_TICK;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 32)      w.cmd = cwm_pkg::CMD_VOTE;
            else if (pick < 57) w.cmd = cwm_pkg::CMD_SIGMA;
            else if (pick < 67) w.cmd = cwm_pkg::CMD_ERRORS;
            else if (pick < 73) w.cmd = cwm_pkg::CMD_START;
            else if (pick < 76) w.cmd = cwm_pkg::CMD_STOP;
            else if (pick < 80) w.cmd = cwm_pkg::CMD_TRIGGER;
            else if (pick < 93) w.cmd = cwm_pkg::CMD_TICK;
            else                w.cmd = cwm_pkg::CMD_BOUNDS;
        end
        case (w.cmd)
            cwm_pkg::CMD_VOTE: begin
                if ($urandom_range(0, 9) < 8)
                    w.src = 4'd0;
                if ($urandom_range(0, 9) < 8)
                    w.cls = cfg_class;
                case ($urandom_range(0, 3))
                    0:       w.vote = '1;
                    1:       w.vote = cwm_pkg::VOTE_W'($urandom);
                    default: w.vote = cwm_pkg::VOTE_W'($urandom_range(0, 300));
                endcase
            end
            cwm_pkg::CMD_SIGMA: begin
                thr = {1'b0, cfg_sigma_thr};
                case ($urandom_range(0, 7))
                    0:       w.sigma = 32'h8000_0000;
                    1:       w.sigma = 32'h7FFF_FFFF;
                    2:       w.sigma = thr;
                    3:       w.sigma = 32'd0 - thr;
                    4:       w.sigma = thr + 32'd1;
                    5:       w.sigma = 32'd0 - (thr + 32'd1);
                    6:       w.sigma = $urandom;
                    default: w.sigma = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
                endcase
            end
            cwm_pkg::CMD_ERRORS: begin
                all_in = ($urandom_range(0, 9) < 6);
                for (j = 0; j < cwm_pkg::JOINT_COUNT; j++) begin
                    if ((all_in || $urandom_range(0, 9) < 7) && bound_lo[j] <= bound_hi[j]) begin
                        span = longint'(bound_hi[j]) - longint'(bound_lo[j]);
                        case ($urandom_range(0, 3))
                            0:       w.err[j] = bound_lo[j];
                            1:       w.err[j] = bound_hi[j];
                            default: w.err[j] = 32'(longint'(bound_lo[j])
                                                + longint'($urandom) % (span + 1));
                        endcase
                    end
                end
            end
            cwm_pkg::CMD_BOUNDS: begin
                w.cls = ($urandom_range(0, 9) < 9)
                      ? 4'($urandom_range(0, cwm_pkg::JOINT_COUNT - 1))
                      : 4'($urandom_range(cwm_pkg::JOINT_COUNT, 15));
                case ($urandom_range(0, 9))
                    0: begin
                        w.err[0] = 32'h8000_0000;
                        w.err[1] = 32'h7FFF_FFFF;
                    end
                    1: ;
                    default: begin
                        a = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                        b = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                        w.err[0] = (a < b) ? a : b;
                        w.err[1] = (a < b) ? b : a;
                    end
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        step_t dir_steps [$];
        int    ph, n, j, burst, gap;
        logic  calm;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = cwm_pkg::CMD_VOTE;
        s_source_id   = '0;
        s_class_index = '0;
        s_vote        = '0;
        s_sigma_value = '0;
        s_err_a = '0; s_err_b = '0; s_err_c = '0; s_err_d = '0;
        s_err_e = '0; s_err_f = '0; s_err_g = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        cfg_class      = cwm_pkg::CLASS_W'(cwm_pkg::RST_CLASS);
        cfg_vote_thr   = cwm_pkg::VOTE_THR_W'(cwm_pkg::RST_VOTE_THR);
        cfg_vote_en    = 1'(cwm_pkg::RST_VOTE_EN);
        cfg_sigma_thr  = cwm_pkg::SIGMA_THR_W'(cwm_pkg::RST_SIGMA_THR);
        cfg_sigma_need = cwm_pkg::SIGMA_NEED_W'(cwm_pkg::RST_SIGMA_NEED);
        cfg_sigma_en   = 1'(cwm_pkg::RST_SIGMA_EN);
        cfg_error_en   = 1'(cwm_pkg::RST_ERROR_EN);
        cfg_blank      = cwm_pkg::BLANK_W'(cwm_pkg::RST_BLANK);
        for (j = 0; j < cwm_pkg::VOTE_WINDOW; j++)
            ring_votes[j] = '0;
        for (j = 0; j < cwm_pkg::SIGMA_WINDOW; j++)
            ring_flags[j] = 1'b0;
        for (j = 0; j < cwm_pkg::JOINT_COUNT; j++) begin
            bound_lo[j] = '0;
            bound_hi[j] = '0;
        end
        vote_sum   = '0;
        vote_pos   = '0;
        flag_count = '0;
        flag_pos   = '0;
        latch      = 1'b1;
        blank_left = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // cmd, src, cls, vote, sigma, err_a, err_b, err_c, chk, ev, det, zr, sum
        dir_steps = '{
            // latch comes up set: trigger and a vote do nothing
            dstep(cwm_pkg::CMD_TRIGGER, 0, 0, 0, 0, 0, 0, 0,            1, 0, 1, 0, 0),
            // most negative sigma still lands in the flag window
            dstep(cwm_pkg::CMD_SIGMA, 0, 0, 0, 32'h8000_0000, 0, 0, 0,  1, 0, 1, 0, 0),
            // load every joint before any joint-error word
            dstep(cwm_pkg::CMD_BOUNDS, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                  1, 0, 1, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 1, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 2, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 3, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 4, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 5, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_BOUNDS, 0, 6, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
                  0, 0, 0, 0, 0),
            // joint index past the end is dropped
            dstep(cwm_pkg::CMD_BOUNDS, 0, 7, 0, 0, 32'h0000_0001, 32'h0000_0000, 0,
                  1, 0, 1, 0, 0),
            dstep(cwm_pkg::CMD_VOTE, 0, 0, 1023, 0, 0, 0, 0,            1, 0, 1, 0, 0),
            dstep(cwm_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 0),
            // blanking: sigma dropped, zeroing requested
            dstep(cwm_pkg::CMD_SIGMA, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,  1, 0, 0, 1, 0),
            dstep(cwm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0,               1, 0, 0, 0, 0),
            // wrong classifier, then wrong class
            dstep(cwm_pkg::CMD_VOTE, 15, 0, 5, 0, 0, 0, 0,              1, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_VOTE, 0, 15, 5, 0, 0, 0, 0,              1, 0, 0, 0, 0),
            dstep(cwm_pkg::CMD_VOTE, 0, 0, 7, 0, 0, 0, 0,               1, 0, 0, 0, 7),
            dstep(cwm_pkg::CMD_ERRORS, 0, 0, 0, 0, 0, 0, 0,             1, 0, 0, 0, 7),
            // sum reaches the threshold exactly
            dstep(cwm_pkg::CMD_VOTE, 0, 0, 1, 0, 0, 0, 0,               1, 1, 1, 0, 8),
            dstep(cwm_pkg::CMD_VOTE, 0, 0, 1023, 0, 0, 0, 0,            1, 0, 1, 0, 8),
            dstep(cwm_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 0,               1, 0, 1, 0, 8),
            dstep(cwm_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 8),
            // joint 2 one LSB past its upper bound
            dstep(cwm_pkg::CMD_ERRORS, 0, 0, 0, 0, 0, 0, 32'h0001_0001, 1, 1, 1, 0, 8),
            dstep(cwm_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 8),
            dstep(cwm_pkg::CMD_TRIGGER, 0, 0, 0, 0, 0, 0, 0,            1, 1, 1, 0, 8)
        };
        foreach (dir_steps[i]) begin
            send_word(dir_steps[i].w, dir_steps[i].chk, dir_steps[i].r);
            if ($urandom_range(0, 1) == 1) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: load_setting(15, 0, 1, 0, 0, 1, 1, 0);
                1: load_setting(5, 16368, 1, 32'h7FFF_FFFF, 16, 1, 0, 65535);
                2: load_setting(0, 20, 0, 65536, 2, 0, 0, 5);
                default: load_setting($urandom_range(0, 15), $urandom_range(0, 3000),
                                      $urandom_range(0, 9) != 0,
                                      $urandom_range(0, 1) ? $urandom_range(0, 32'h0003_0000)
                                                           : $urandom_range(0, 32'h7FFF_FFFF),
                                      $urandom_range(0, 8), $urandom_range(0, 9) != 0,
                                      $urandom_range(0, 9) != 0, $urandom_range(0, 8));
            endcase
            calm  = (ph == 2);
            burst = $urandom_range(1, 16);
            for (n = 0; n < WORDS_PER_PASS; n++) begin
                // long receiver hold-off while the sender keeps pushing
                if (ph == 3 && n == 20)
                    hold_left = 300;
                // pause the sender until the pipe is empty
                if (ph == 3 && n == 60) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    while (status_q.size() != 0)
                        @(posedge aclk);
                end
                send_word(gen_word(), 1'b0, '0);
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 16);
                    if (!calm && !(ph == 3 && n >= 20 && n < 60)) begin
                        gap = $urandom_range(1, 6);
                        @(negedge aclk);
                        s_valid <= 1'b0;
                        repeat (gap - 1) @(negedge aclk);
                    end
                end
            end
        end

        drain();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
